// ===== hdl/lmx_pkg.sv =====
`timescale 1ns / 1ps
// lmx_pkg: shared constants, register indexes and stage payload types
// for the led matrix coordinate mapper; no dependencies
package lmx_pkg;

   // geometry
   localparam int MATRIX_HEIGHT = 8;

   // field widths
   localparam int COL_W     = 5;
   localparam int ROW_W     = 3;
   localparam int PW_W      = 6;
   localparam int CORNER_W  = 2;
   localparam int WD_W      = 2 * PW_W;
   localparam int QUO_W     = 6;
   localparam int IDX_W     = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = PW_W;

   // quotient bits resolved in one divider stage
   localparam int DIV_STEPS = 3;

   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MATRIX_HEIGHT - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PANEL_WIDTH   = 3'd0,
      REG_PANEL_COUNT   = 3'd1,
      REG_START_CORNER  = 3'd2,
      REG_COLUMN_WIRING = 3'd3,
      REG_SERPENTINE    = 3'd4,
      REG_MIRROR_X      = 3'd5,
      REG_ROTATE_HALF   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [PW_W-1:0]     panel_width;
      logic [PW_W-1:0]     panel_count;
      logic [CORNER_W-1:0] start_corner;
      logic                column_wiring;
      logic                serpentine;
      logic                mirror_x;
      logic                rotate_half;
   } cfg_type;

   // divider state: partial remainder, dividend bits still to shift in, quotient so far
   typedef struct packed {
      logic             oor;
      logic [PW_W-1:0]  rem;
      logic [QUO_W-1:0] dvd;
      logic [QUO_W-1:0] quo;
      logic [ROW_W-1:0] row;
   } div_type;

   typedef struct packed {
      logic             oor;
      logic [QUO_W-1:0] panel;
      logic [PW_W-1:0]  lane;
      logic [PW_W-1:0]  ofs;
   } map_type;

   typedef struct packed {
      logic             oor;
      logic [IDX_W-1:0] base;
      logic [IDX_W-1:0] loc;
   } mul_type;

endpackage

// ===== hdl/lmx_prep.sv =====
`timescale 1ns / 1ps
// lmx_prep: first pipeline stage, range check plus mirror and rotation
// depends on lmx_pkg
module lmx_prep import lmx_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [COL_W-1:0] col,
   input  logic [ROW_W-1:0] row,
   output logic             out_valid,
   input  logic             out_ready,
   output div_type          out_data
);

   logic            valid_ff;
   div_type         data_ff;
   div_type         data_in;
   logic [WD_W-1:0] total_width;
   logic [WD_W-1:0] col_ext;
   logic [WD_W-1:0] col_flip;
   logic            flip_x;

   assign total_width = WD_W'(cfg.panel_width) * WD_W'(cfg.panel_count);
   assign col_ext     = WD_W'(col);
   // mirror and half turn both flip the column, so together they cancel
   assign flip_x      = cfg.mirror_x ^ cfg.rotate_half;
   assign col_flip    = flip_x ? (total_width - WD_W'(1) - col_ext) : col_ext;

   always_comb begin
      data_in.oor = (col_ext >= total_width) || (int'(row) >= MATRIX_HEIGHT);
      data_in.rem = col_flip[WD_W-1:QUO_W];
      data_in.dvd = col_flip[QUO_W-1:0];
      data_in.quo = '0;
      data_in.row = cfg.rotate_half ? (ROW_LAST - row) : row;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== hdl/lmx_div.sv =====
`timescale 1ns / 1ps
// lmx_div: one restoring divider stage, resolves a few quotient bits of
// column / panel width; depends on lmx_pkg
module lmx_div import lmx_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    in_valid,
   output logic    in_ready,
   input  div_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output div_type out_data
);

   logic    valid_ff;
   div_type data_ff;
   div_type data_in;

   always_comb begin
      logic [PW_W:0] trial;
      div_type       acc;
      acc   = in_data;
      trial = '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
         trial = {acc.rem, acc.dvd[QUO_W-1]};
         if (trial >= {1'b0, cfg.panel_width}) begin
            acc.rem = PW_W'(trial - {1'b0, cfg.panel_width});
            acc.quo = {acc.quo[QUO_W-2:0], 1'b1};
         end else begin
            acc.rem = trial[PW_W-1:0];
            acc.quo = {acc.quo[QUO_W-2:0], 1'b0};
         end
         acc.dvd = {acc.dvd[QUO_W-2:0], 1'b0};
      end
      data_in = acc;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== hdl/lmx_map.sv =====
`timescale 1ns / 1ps
// lmx_map: panel order and in-panel lane / offset from the start corner
// and serpentine setting; depends on lmx_pkg
module lmx_map import lmx_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    in_valid,
   output logic    in_ready,
   input  div_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output map_type out_data
);

   logic            valid_ff;
   map_type         data_ff;
   map_type         data_in;
   logic            from_right;
   logic            from_bottom;
   logic [PW_W-1:0] pw_last;
   logic [PW_W-1:0] col_lane;
   logic [ROW_W-1:0] col_pos;
   logic [ROW_W-1:0] row_lane;
   logic [PW_W-1:0] row_pos;

   assign from_right  = cfg.start_corner[0];
   assign from_bottom = cfg.start_corner[1];
   assign pw_last     = cfg.panel_width - PW_W'(1);

   // column runs
   assign col_lane = from_right ? (pw_last - in_data.rem) : in_data.rem;
   assign col_pos  = (cfg.serpentine && col_lane[0]) ? (ROW_LAST - in_data.row) : in_data.row;
   // row runs
   assign row_lane = from_bottom ? (ROW_LAST - in_data.row) : in_data.row;
   assign row_pos  = (cfg.serpentine && row_lane[0]) ? (pw_last - in_data.rem) : in_data.rem;

   always_comb begin
      data_in.oor   = in_data.oor;
      data_in.panel = from_right ? (cfg.panel_count - PW_W'(1) - in_data.quo) : in_data.quo;
      if (cfg.column_wiring) begin
         data_in.lane = col_lane;
         data_in.ofs  = PW_W'(from_bottom ? (ROW_LAST - col_pos) : col_pos);
      end else begin
         data_in.lane = PW_W'(row_lane);
         data_in.ofs  = from_right ? (pw_last - row_pos) : row_pos;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== hdl/lmx_mul.sv =====
`timescale 1ns / 1ps
// lmx_mul: panel base and in-panel position products, kept modulo the
// strip index width; depends on lmx_pkg
module lmx_mul import lmx_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    in_valid,
   output logic    in_ready,
   input  map_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output mul_type out_data
);

   logic            valid_ff;
   mul_type         data_ff;
   mul_type         data_in;
   logic [PW_W-1:0] run_len;
   logic [WD_W-1:0] lane_prod;
   logic [WD_W-1:0] panel_prod;

   // run length is the panel height for column runs, the panel width for row runs
   assign run_len    = cfg.column_wiring ? PW_W'(MATRIX_HEIGHT) : cfg.panel_width;
   assign lane_prod  = WD_W'(in_data.lane) * WD_W'(run_len);
   assign panel_prod = WD_W'(in_data.panel) * WD_W'(cfg.panel_width);

   always_comb begin
      data_in.oor  = in_data.oor;
      data_in.base = panel_prod[IDX_W-1:0];
      data_in.loc  = lane_prod[IDX_W-1:0] + IDX_W'(in_data.ofs);
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== hdl/led_matrix_xy_to_index_core.sv =====
`timescale 1ns / 1ps
// led_matrix_xy_to_index_core: top level of the led matrix coordinate mapper
// depends on lmx_pkg, lmx_prep, lmx_div, lmx_mul and lmx_map
//
// maps a pixel (col, row) to the position of its led along the strip of a
// matrix built from equal panels side by side. one beat is taken per clock
// and one result beat leaves per clock while rsp_tready holds high; each beat
// goes through six register stages (range check and mirror/rotate, two
// restoring divider stages for the panel number and column inside it, corner
// and serpentine mapping, the two products, final sum in the output register)
// on its way to rsp_tvalid. each stage holds its beat until the next one has
// room, so stalls on rsp_tready lose and repeat nothing and bubbles are
// squeezed out. a column at or beyond the total width gives out_of_range set
// and index 0; larger layouts wrap to 8 bits. the csr registers must only be
// written while no beat is in flight.
module led_matrix_xy_to_index_core import lmx_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [4:0] col, [7:5] row
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [7:0] led_index
   output logic                  rsp_tuser,   // [0] out_of_range
   // configuration writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type          cfg_ff;
   logic             prep_valid;
   logic             prep_ready;
   div_type          prep_data;
   logic             div1_valid;
   logic             div1_ready;
   div_type          div1_data;
   logic             div2_valid;
   logic             div2_ready;
   div_type          div2_data;
   logic             map_valid;
   logic             map_ready;
   map_type          map_data;
   logic             mul_valid;
   logic             mul_ready;
   mul_type          mul_data;
   logic             rsp_valid_ff;
   logic [IDX_W-1:0] rsp_index_ff;
   logic [IDX_W-1:0] rsp_index_in;
   logic             rsp_oor_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.panel_width   <= PW_W'(32);
         cfg_ff.panel_count   <= PW_W'(1);
         cfg_ff.start_corner  <= '0;
         cfg_ff.column_wiring <= 1'b0;
         cfg_ff.serpentine    <= 1'b0;
         cfg_ff.mirror_x      <= 1'b0;
         cfg_ff.rotate_half   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            REG_PANEL_WIDTH:   cfg_ff.panel_width   <= csr_wdata;
            REG_PANEL_COUNT:   cfg_ff.panel_count   <= csr_wdata;
            REG_START_CORNER:  cfg_ff.start_corner  <= csr_wdata[CORNER_W-1:0];
            REG_COLUMN_WIRING: cfg_ff.column_wiring <= csr_wdata[0];
            REG_SERPENTINE:    cfg_ff.serpentine    <= csr_wdata[0];
            REG_MIRROR_X:      cfg_ff.mirror_x      <= csr_wdata[0];
            REG_ROTATE_HALF:   cfg_ff.rotate_half   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // stage 1: range check, mirror and half turn
   lmx_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .col       (req_tdata[COL_W-1:0]),
      .row       (req_tdata[COL_W+ROW_W-1:COL_W]),
      .out_valid (prep_valid),
      .out_ready (prep_ready),
      .out_data  (prep_data)
   );

   // stages 2 and 3: panel number and column inside the panel
   lmx_div u_div1 (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_data   (prep_data),
      .out_valid (div1_valid),
      .out_ready (div1_ready),
      .out_data  (div1_data)
   );

   lmx_div u_div2 (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (div1_valid),
      .in_ready  (div1_ready),
      .in_data   (div1_data),
      .out_valid (div2_valid),
      .out_ready (div2_ready),
      .out_data  (div2_data)
   );

   // stage 4: start corner and serpentine
   lmx_map u_map (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (div2_valid),
      .in_ready  (div2_ready),
      .in_data   (div2_data),
      .out_valid (map_valid),
      .out_ready (map_ready),
      .out_data  (map_data)
   );

   // stage 5: products
   lmx_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (map_valid),
      .in_ready  (map_ready),
      .in_data   (map_data),
      .out_valid (mul_valid),
      .out_ready (mul_ready),
      .out_data  (mul_data)
   );

   // stage 6: panel base scaled by the height plus in-panel position
   assign rsp_index_in = mul_data.oor ? '0
                       : (IDX_W'(mul_data.base * IDX_W'(MATRIX_HEIGHT)) + mul_data.loc);

   assign mul_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (mul_ready) begin
         rsp_valid_ff <= mul_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ready && mul_valid) begin
         rsp_index_ff <= rsp_index_in;
         rsp_oor_ff   <= mul_data.oor;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_index_ff;
   assign rsp_tuser  = rsp_oor_ff;

endmodule

// ===== verif/led_matrix_xy_to_index_checker.sv =====
`timescale 1ns / 1ps
// led_matrix_xy_to_index_checker: watches the request, result and csr ports of
// the led matrix mapper, predicts every result beat and compares; uses lmx_pkg
module led_matrix_xy_to_index_checker import lmx_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [4:0] col, [7:5] row
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [7:0]            rsp_tdata,   // [7:0] led_index
   input  logic                  rsp_tuser,   // [0] out_of_range
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending
);

   typedef struct packed {
      logic [IDX_W-1:0] led_index;
      logic             out_of_range;
   } led_slot_type;

   cfg_type      layout;
   led_slot_type led_slots_due [$];
   int           errors = 0;

   // strip position of one pixel under the given layout
   function automatic led_slot_type locate_led(cfg_type c, logic [COL_W-1:0] col,
                                               logic [ROW_W-1:0] row);
      led_slot_type slot;
      int unsigned  x, y, ht, pw, pc, wd, panel, cx, lane, pos, ofs;
      bit           from_right, from_bottom;
      ht          = MATRIX_HEIGHT;
      pw          = c.panel_width;
      pc          = c.panel_count;
      wd          = pw * pc;
      x           = col;
      y           = row;
      from_right  = c.start_corner[0];
      from_bottom = c.start_corner[1];
      slot        = '0;
      if (x >= wd || y >= ht) begin
         slot.out_of_range = 1'b1;
         return slot;
      end
      if (c.mirror_x)
         x = wd - 1 - x;
      if (c.rotate_half) begin
         x = wd - 1 - x;
         y = ht - 1 - y;
      end
      panel = x / pw;
      if (from_right)
         panel = pc - 1 - panel;
      cx = x % pw;
      if (c.column_wiring) begin
         lane = from_right ? pw - 1 - cx : cx;
         pos  = (c.serpentine && (lane % 2 == 1)) ? ht - 1 - y : y;
         ofs  = lane * ht + (from_bottom ? ht - 1 - pos : pos);
      end else begin
         lane = from_bottom ? ht - 1 - y : y;
         pos  = (c.serpentine && (lane % 2 == 1)) ? pw - 1 - cx : cx;
         ofs  = lane * pw + (from_right ? pw - 1 - pos : pos);
      end
      slot.led_index = IDX_W'(panel * (pw * ht) + ofs);
      return slot;
   endfunction

   always @(posedge clock) begin : watch
      led_slot_type due;
      if (reset) begin
         layout        <= '{panel_width: 6'd32, panel_count: 6'd1, default: '0};
         led_slots_due.delete();
      end else begin
         if (req_tvalid && req_tready)
            led_slots_due.push_back(locate_led(layout, req_tdata[4:0], req_tdata[7:5]));
         if (rsp_tvalid && rsp_tready) begin
            if (led_slots_due.size() == 0) begin
               $error("unexpected result beat: led_index actual %0d, out_of_range actual %0d",
                      rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               due = led_slots_due.pop_front();
               if (rsp_tdata !== due.led_index) begin
                  $error("led_index: expected %0d, actual %0d", due.led_index, rsp_tdata);
                  errors++;
               end
               if (rsp_tuser !== due.out_of_range) begin
                  $error("out_of_range: expected %0d, actual %0d",
                         due.out_of_range, rsp_tuser);
                  errors++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               REG_PANEL_WIDTH:   layout.panel_width   <= csr_wdata[PW_W-1:0];
               REG_PANEL_COUNT:   layout.panel_count   <= csr_wdata[PW_W-1:0];
               REG_START_CORNER:  layout.start_corner  <= csr_wdata[CORNER_W-1:0];
               REG_COLUMN_WIRING: layout.column_wiring <= csr_wdata[0];
               REG_SERPENTINE:    layout.serpentine    <= csr_wdata[0];
               REG_MIRROR_X:      layout.mirror_x      <= csr_wdata[0];
               REG_ROTATE_HALF:   layout.rotate_half   <= csr_wdata[0];
               default: ;
            endcase
         end
      end
      pending    <= led_slots_due.size();
      fail_count <= errors;
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// testbench: stimulus and verdict for led_matrix_xy_to_index_core
// depends on lmx_pkg, the core and led_matrix_xy_to_index_checker
module testbench;
   import lmx_pkg::*;

   // index past the end of the register list, writes to it must be ignored
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 3'd7;
   // length of the long result hold-off that backs the pipeline up
   localparam int HOLD_CYCLES = 64;
   localparam int RANDOM_ITEMS = 1300;
   localparam int DRAIN_CYCLES = 20;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;   // [4:0] col, [7:5] row
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;         // [7:0] led_index
   logic                  rsp_tuser;         // [0] out_of_range
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int fail_count;
   int pending;

   // per-phase idling switches; the stimulus toggles hold_sink to ask the
   // result side for a long hold-off
   bit source_idle = 1'b0;
   bit sink_idle   = 1'b0;
   bit hold_sink   = 1'b0;

   led_matrix_xy_to_index_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   led_matrix_xy_to_index_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // 12 ns clock
   initial begin
      forever #6 clock = ~clock;
   end

   // single reset pulse at the start
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // safety net well beyond the slowest legal run
   initial begin
      #(5_000_000);
      $display("Some tests failed");
      $finish;
   end

   // result side: after each beat draw a stall, or take the long hold-off when asked
   initial begin : result_sink
      int stall;
      bit hold_seen;
      stall     = 0;
      hold_seen = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            stall = sink_idle ? $urandom_range(0, 8) : 0;
         if (hold_sink != hold_seen) begin
            stall     = HOLD_CYCLES;
            hold_seen = hold_sink;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // offer one pixel beat after an optional gap; returns at the accepting edge.
   // tvalid is only lowered when a gap follows, so back-to-back beats keep it high
   task automatic send_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
      int gap;
      gap = source_idle ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {row, col};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // stop offering and wait until every predicted result beat has come back
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // write the whole register set while the pipeline is empty; with noisy set the
   // unused upper data bits are random and the spare index gets a write as well
   task automatic apply_layout(input logic [PW_W-1:0] pw, input logic [PW_W-1:0] pc,
                               input logic [CORNER_W-1:0] corner, input logic colw,
                               input logic serp, input logic mir, input logic rot,
                               input bit noisy);
      logic [CSR_DATA_W-1:0] pad;
      pad = noisy ? CSR_DATA_W'($urandom) : '0;
      csr_we    <= 1'b1;
      csr_index <= REG_PANEL_WIDTH;
      csr_wdata <= pw;
      @(posedge clock);
      csr_index <= REG_PANEL_COUNT;
      csr_wdata <= pc;
      @(posedge clock);
      csr_index <= REG_START_CORNER;
      csr_wdata <= {pad[CSR_DATA_W-1:CORNER_W], corner};
      @(posedge clock);
      csr_index <= REG_COLUMN_WIRING;
      csr_wdata <= {pad[CSR_DATA_W-1:1], colw};
      @(posedge clock);
      csr_index <= REG_SERPENTINE;
      csr_wdata <= {pad[CSR_DATA_W-1:1], serp};
      @(posedge clock);
      csr_index <= REG_MIRROR_X;
      csr_wdata <= {pad[CSR_DATA_W-1:1], mir};
      @(posedge clock);
      csr_index <= REG_ROTATE_HALF;
      csr_wdata <= {pad[CSR_DATA_W-1:1], rot};
      @(posedge clock);
      if (noisy) begin
         csr_index <= REG_SPARE;
         csr_wdata <= CSR_DATA_W'($urandom);
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      int              random_items;
      int              phase;
      int              count;
      int              kind;
      int              wd;
      int              limit;
      logic [PW_W-1:0] pw;
      logic [PW_W-1:0] pc;
      logic [COL_W-1:0] col;

      wait (!reset);
      @(posedge clock);

      // ---- directed part ----
      // reset layout: one 32 wide panel, rows from the top-left
      send_pixel(5'd0, 3'd0);
      send_pixel(5'd31, 3'd7);
      send_pixel(5'd17, 3'd4);
      drain();

      // four panels, column runs from bottom-right, serpentine
      apply_layout(6'd8, 6'd4, 2'd3, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
      send_pixel(5'd0, 3'd0);
      send_pixel(5'd31, 3'd7);
      send_pixel(5'd9, 3'd1);
      drain();

      // rows from top-right, serpentine, mirrored and rotated at once
      apply_layout(6'd8, 6'd4, 2'd1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
      send_pixel(5'd0, 3'd0);
      send_pixel(5'd31, 3'd7);
      send_pixel(5'd10, 3'd2);
      drain();

      // narrowest panels, most of them, columns from bottom-left
      apply_layout(6'd1, 6'd32, 2'd2, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
      send_pixel(5'd0, 3'd7);
      send_pixel(5'd31, 3'd0);
      drain();

      // matrix narrower than the column range: last column in, then beyond it
      apply_layout(6'd5, 6'd3, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_pixel(5'd14, 3'd7);
      send_pixel(5'd15, 3'd0);
      send_pixel(5'd31, 3'd3);
      drain();

      // zero panel width, then zero panel count: nothing is inside the matrix
      apply_layout(6'd0, 6'd4, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_pixel(5'd0, 3'd0);
      send_pixel(5'd31, 3'd7);
      drain();
      apply_layout(6'd4, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_pixel(5'd0, 3'd0);
      send_pixel(5'd3, 3'd5);
      drain();

      // oversized layout, index wraps to 8 bits
      apply_layout(6'd63, 6'd63, 2'd3, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
      send_pixel(5'd0, 3'd0);
      send_pixel(5'd31, 3'd7);
      send_pixel(5'd20, 3'd3);
      drain();

      // single full-width panel, rows from bottom-left, serpentine
      apply_layout(6'd32, 6'd1, 2'd2, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
      send_pixel(5'd0, 3'd0);
      send_pixel(5'd31, 3'd7);
      send_pixel(5'd1, 3'd1);
      drain();

      // ---- random part: phases of one layout each ----
      random_items = 0;
      phase        = 0;
      while (random_items < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            // anything the registers can hold, including zero and oversized
            pw = PW_W'($urandom);
            pc = PW_W'($urandom);
         end else begin
            pw = (kind == 1) ? 6'd1 : (kind == 2) ? 6'd32 : PW_W'($urandom_range(1, 32));
            pc = (kind == 3) ? PW_W'(32 / pw) : PW_W'($urandom_range(1, 32 / pw));
         end
         apply_layout(pw, pc, CORNER_W'($urandom), 1'($urandom), 1'($urandom),
                      1'($urandom), 1'($urandom), $urandom_range(0, 3) == 0);
         wd    = int'(pw) * int'(pc);
         limit = (wd > 32) ? 32 : wd;
         count = $urandom_range(20, 60);

         // idling switched per phase so some phases run flat out
         source_idle = $urandom_range(0, 3) != 0;
         sink_idle   = $urandom_range(0, 3) != 0;
         if (phase % 9 == 1) begin
            // result side holds off while requests keep coming, filling every stage
            source_idle = 1'b0;
            hold_sink   = ~hold_sink;
         end

         repeat (count) begin
            // mostly pixels inside the matrix, the rest anywhere in the column range
            if (wd > 0 && $urandom_range(0, 3) != 0)
               col = COL_W'($urandom_range(0, limit - 1));
            else
               col = COL_W'($urandom);
            send_pixel(col, ROW_W'($urandom));
         end
         random_items += count;
         drain();
         phase++;
      end

      // idle on before the verdict so a stray late beat would still be caught
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
